// ===== sv/vrw_pkg.sv =====
// ----------------------------------------------------------------------------
// vrw_pkg: shared types and constants for the vibration RMS window core
// Register indexes, field widths, reset values and the sequencer states.
// ----------------------------------------------------------------------------
package vrw_pkg;

	// Field and state widths fixed by the register map and result format
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int WIN_W            = 8;
	localparam int GRAV_W           = 15;
	localparam int SUM_W            = 40;
	localparam int RMS_W            = 16;
	localparam int CFG_IDX_W        = 2;
	localparam int CFG_DATA_W       = 15;

	// Register reset values
	localparam logic [WIN_W-1:0]  WINDOW_LENGTH_RST  = 8'd50;
	localparam logic [GRAV_W-1:0] GRAVITY_OFFSET_RST = 15'd4096;

	// Saturation limits
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
	localparam logic [RMS_W-1:0] RMS_MAX = {RMS_W{1'b1}};

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_OFFSET = 2'd1;

	// Sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_SQX,
		S_SQY,
		S_SQZ,
		S_MAG_START,
		S_MAG_WAIT,
		S_SQD,
		S_ACC,
		S_CHECK,
		S_DIV_START,
		S_DIV_WAIT,
		S_RT_START,
		S_RT_WAIT,
		S_OUT
	} vrw_state_t;

endpackage

// ===== sv/vrw_isqrt.sv =====
// ----------------------------------------------------------------------------
// vrw_isqrt: iterative floor integer square root
// Digit-by-digit method, one root bit per cycle.
// ----------------------------------------------------------------------------
module vrw_isqrt #(
	parameter int IN_W = 40
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [IN_W-1:0]     operand,
	output logic                done,
	output logic [IN_W/2-1:0]   root
);

	localparam int RT_W  = IN_W / 2;
	localparam int REM_W = RT_W + 2;
	localparam int CNT_W = $clog2(RT_W + 1);

	logic [IN_W-1:0]  opnd_q;
	logic [REM_W-1:0] rem_q;
	logic [RT_W-1:0]  root_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [REM_W-1:0] rem_sh;
	logic [REM_W-1:0] trial;
	logic             fits;

	// one step: bring down two operand bits, try the next root bit
	assign rem_sh = {rem_q[RT_W-1:0], opnd_q[IN_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign fits   = (rem_sh >= trial);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(RT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			opnd_q <= operand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			opnd_q <= {opnd_q[IN_W-3:0], 2'b00};
			rem_q  <= fits ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[RT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== sv/vrw_div.sv =====
// ----------------------------------------------------------------------------
// vrw_div: iterative restoring divider
// Unsigned N_W by D_W bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vrw_div
	import vrw_pkg::*;
#(
	parameter int N_W = SUM_W,
	parameter int D_W = WIN_W
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [N_W-1:0]  dividend,
	input  logic [D_W-1:0]  divisor,
	output logic            done,
	output logic [N_W-1:0]  quotient
);

	localparam int CNT_W = $clog2(N_W + 1);

	logic [N_W-1:0]   quot_q;
	logic [D_W-1:0]   rem_q;
	logic [D_W-1:0]   dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [D_W:0]     rem_sh;
	logic [D_W:0]     rem_sub;
	logic             ge;

	// shift in the next dividend bit and try a subtract
	assign rem_sh  = {rem_q, quot_q[N_W-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign ge      = (rem_sh >= {1'b0, dvs_q});

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(N_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath: dividend bits leave at the top, quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[N_W-2:0], ge};
			rem_q  <= ge ? rem_sub[D_W-1:0] : rem_sh[D_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

// ===== sv/vibration_rms_window_core.sv =====
// ----------------------------------------------------------------------------
// vibration_rms_window_core: windowed RMS of acceleration magnitude
// Sequencer around one shared multiplier, one shared square root unit and a divider.
// ----------------------------------------------------------------------------
// Each accepted sample (x, y, z, signed, 12 fraction bits) is turned into its
// vector magnitude floor(sqrt(x^2+y^2+z^2)), offset by gravity_offset, and the
// squared difference is added to a 40-bit accumulator that saturates. After
// window_length samples (zero counts as one) one rms_value is delivered:
// floor(sqrt(sum / samples)), saturated to 16 bits. One squaring multiplier is
// reused for the three axes and the difference; one iterative square root
// unit (one root bit per cycle) serves both the magnitude and the final RMS;
// a restoring divider forms the mean. in_ready stays low from the acceptance
// of a sample until the sequencer is back in idle, so samples are taken one
// at a time; a sample that closes a window also waits there until its result
// can enter the output register, which is not free while an earlier result
// still waits. The result sits in an output register, so the next sample may
// be taken while it waits. Configuration must be written only while the core
// is idle.
// ----------------------------------------------------------------------------
module vibration_rms_window_core
	import vrw_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_we,
	input  logic [CFG_IDX_W-1:0]           cfg_index,
	input  logic [CFG_DATA_W-1:0]          cfg_data,
	// sample input
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] accel_x,
	input  logic signed [SAMPLE_WIDTH-1:0] accel_y,
	input  logic signed [SAMPLE_WIDTH-1:0] accel_z,
	// result output
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [RMS_W-1:0]               rms_value
);

	localparam int MUL_W  = (SAMPLE_WIDTH > GRAV_W) ? SAMPLE_WIDTH : GRAV_W;
	localparam int PROD_W = 2 * MUL_W;
	localparam int MAG_W  = 2 * SAMPLE_WIDTH;
	localparam int SQ_W   = (MAG_W > SUM_W) ? MAG_W : SUM_W;
	localparam int RT_W   = SQ_W / 2;
	localparam int ACC_W  = ((PROD_W > SUM_W) ? PROD_W : SUM_W) + 1;

	vrw_state_t state_q, state_d;

	// configuration registers
	logic [WIN_W-1:0]  window_length_q;
	logic [GRAV_W-1:0] gravity_offset_q;

	// datapath registers
	logic [SAMPLE_WIDTH-1:0] ax_q, ay_q, az_q;
	logic [PROD_W-1:0]       prod_q;
	logic [MAG_W-1:0]        magsum_q;
	logic [MUL_W-1:0]        diff_q;
	logic [SUM_W-1:0]        sum_q;
	logic [WIN_W-1:0]        count_q;
	logic [RMS_W-1:0]        rms_q;
	logic                    out_valid_q;

	// combinational
	logic [SAMPLE_WIDTH-1:0] ax_abs, ay_abs, az_abs;
	logic [MUL_W-1:0]        mul_op;
	logic [PROD_W-1:0]       mul_res;
	logic [MUL_W-1:0]        mag;
	logic [MUL_W-1:0]        grav;
	logic [MUL_W-1:0]        diff_d;
	logic [ACC_W-1:0]        acc_sum;
	logic [SUM_W-1:0]        sum_sat;
	logic [WIN_W:0]          taken;
	logic [WIN_W:0]          win;
	logic                    window_done;
	logic                    out_free;
	logic [RMS_W-1:0]        rms_sat;

	logic                    in_accept;
	logic                    rt_start;
	logic [SQ_W-1:0]         rt_operand;
	logic                    rt_done;
	logic [RT_W-1:0]         rt_root;
	logic                    div_start;
	logic                    div_done;
	logic [SUM_W-1:0]        div_quot;

	// absolute value of each axis; the most negative code maps to 2^(SW-1)
	assign ax_abs = accel_x[SAMPLE_WIDTH-1] ? (~$unsigned(accel_x) + 1'b1) : $unsigned(accel_x);
	assign ay_abs = accel_y[SAMPLE_WIDTH-1] ? (~$unsigned(accel_y) + 1'b1) : $unsigned(accel_y);
	assign az_abs = accel_z[SAMPLE_WIDTH-1] ? (~$unsigned(accel_z) + 1'b1) : $unsigned(accel_z);

	// shared squaring multiplier
	assign mul_res = mul_op * mul_op;

	// magnitude minus gravity, as an absolute difference
	assign mag    = rt_root[MUL_W-1:0];
	assign grav   = MUL_W'(gravity_offset_q);
	assign diff_d = (mag >= grav) ? (mag - grav) : (grav - mag);

	// saturating accumulate
	assign acc_sum = ACC_W'(sum_q) + ACC_W'(prod_q);
	assign sum_sat = (acc_sum > ACC_W'(SUM_MAX)) ? SUM_MAX : acc_sum[SUM_W-1:0];

	// window bookkeeping; a zero length behaves as one
	assign taken       = (WIN_W+1)'(count_q) + 1'b1;
	assign win         = (window_length_q == '0) ? (WIN_W+1)'(1) : (WIN_W+1)'(window_length_q);
	assign window_done = (taken >= win);

	assign out_free  = !out_valid_q || out_ready;
	assign rms_sat   = (rt_root > RT_W'(RMS_MAX)) ? RMS_MAX : rt_root[RMS_W-1:0];
	assign in_accept = in_valid && in_ready;

	// shared square root unit and the divider
	vrw_isqrt #(
		.IN_W (SQ_W)
	) u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (rt_start),
		.operand (rt_operand),
		.done    (rt_done),
		.root    (rt_root)
	);

	vrw_div #(
		.N_W (SUM_W),
		.D_W (WIN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (taken[WIN_W-1:0]),
		.done     (div_done),
		.quotient (div_quot)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:      if (in_accept) state_d = S_SQX;
			S_SQX:       state_d = S_SQY;
			S_SQY:       state_d = S_SQZ;
			S_SQZ:       state_d = S_MAG_START;
			S_MAG_START: state_d = S_MAG_WAIT;
			S_MAG_WAIT:  if (rt_done) state_d = S_SQD;
			S_SQD:       state_d = S_ACC;
			S_ACC:       state_d = S_CHECK;
			S_CHECK:     state_d = window_done ? S_DIV_START : S_IDLE;
			S_DIV_START: state_d = S_DIV_WAIT;
			S_DIV_WAIT:  if (div_done) state_d = S_RT_START;
			S_RT_START:  state_d = S_RT_WAIT;
			S_RT_WAIT:   if (rt_done) state_d = S_OUT;
			S_OUT:       if (out_free) state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready   = 1'b0;
		rt_start   = 1'b0;
		div_start  = 1'b0;
		mul_op     = diff_q;
		rt_operand = SQ_W'(div_quot);
		case (state_q)
			S_IDLE:      in_ready = 1'b1;
			S_SQX:       mul_op = MUL_W'(ax_q);
			S_SQY:       mul_op = MUL_W'(ay_q);
			S_SQZ:       mul_op = MUL_W'(az_q);
			S_MAG_START: begin
				rt_start   = 1'b1;
				rt_operand = SQ_W'(magsum_q + prod_q[MAG_W-1:0]);
			end
			S_DIV_START: div_start = 1'b1;
			S_RT_START:  rt_start = 1'b1;
			default:     mul_op = diff_q;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q  <= WINDOW_LENGTH_RST;
			gravity_offset_q <= GRAVITY_OFFSET_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WINDOW_LENGTH:  window_length_q  <= cfg_data[WIN_W-1:0];
				CFG_GRAVITY_OFFSET: gravity_offset_q <= cfg_data[GRAV_W-1:0];
				default:            ;
			endcase
		end
	end

	// window state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result takes over the register as the old one leaves
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_ACC:   sum_q <= sum_sat;
				S_CHECK: if (!window_done) count_q <= taken[WIN_W-1:0];
				S_OUT:   begin
					if (out_free) begin
						sum_q   <= '0;
						count_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					ax_q <= ax_abs;
					ay_q <= ay_abs;
					az_q <= az_abs;
				end
			end
			S_SQX:      prod_q <= mul_res;
			S_SQY: begin
				magsum_q <= prod_q[MAG_W-1:0];
				prod_q   <= mul_res;
			end
			S_SQZ: begin
				magsum_q <= magsum_q + prod_q[MAG_W-1:0];
				prod_q   <= mul_res;
			end
			S_MAG_WAIT: if (rt_done) diff_q <= diff_d;
			S_SQD:      prod_q <= mul_res;
			S_OUT:      if (out_free) rms_q <= rms_sat;
			default:    ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign rms_value = rms_q;

	// square root results only arrive while the sequencer waits for them
	a_rt_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		rt_done |-> (state_q == S_MAG_WAIT || state_q == S_RT_WAIT))
		else $error("square root finished outside a wait state");

	// divider results only arrive while the sequencer waits for them
	a_div_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV_WAIT))
		else $error("divider finished outside its wait state");

	// the sample count never reaches the largest code
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != {WIN_W{1'b1}})
		else $error("sample count out of range");

	// delivering a result clears the window
	a_window_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_free) |=> (sum_q == '0 && count_q == '0 && out_valid_q))
		else $error("window not cleared after result");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for vibration_rms_window_core
// Three-axis samples go in through a valid/ready driver and RMS results come
// back through a stalling receiver. A cycle-free predictor keeps its own copy
// of the window registers, accumulator and sample count, and each RMS
// transaction is compared against the oldest predicted value. Registers are
// only changed while the core is idle, between stimulus phases.
// ----------------------------------------------------------------------------
module tb;
	import vrw_pkg::*;

	localparam int SAMPLE_W        = SAMPLE_WIDTH_DEF;
	localparam int RANDOM_ITEMS    = 900;
	localparam int IDLE_SETTLE     = 150;
	localparam int PRESSURE_CYCLES = 1500;
	localparam int WATCHDOG_LIMIT  = 6000;
	localparam int REPORT_LIMIT    = 10;

	// Indexes outside the register map; writes to them must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] x;
		logic signed [SAMPLE_W-1:0] y;
		logic signed [SAMPLE_W-1:0] z;
	} sample_t;

	// DUT signals
	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [CFG_DATA_W-1:0]      cfg_data  = '0;
	logic                       in_valid  = 1'b0;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] accel_x   = '0;
	logic signed [SAMPLE_W-1:0] accel_y   = '0;
	logic signed [SAMPLE_W-1:0] accel_z   = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [RMS_W-1:0]           rms_value;

	// Pending samples and predicted RMS values
	sample_t          sample_q[$];
	logic [RMS_W-1:0] rms_expected[$];

	// Predictor copy of registers and window state
	logic [WIN_W-1:0]  win_cfg   = WINDOW_LENGTH_RST;
	logic [GRAV_W-1:0] grav_cfg  = GRAVITY_OFFSET_RST;
	logic [SUM_W-1:0]  acc_sum   = '0;
	logic [WIN_W-1:0]  acc_count = '0;

	// Handshake pacing
	logic in_fire       = 1'b0;
	int   in_gap        = 0;
	int   out_hold      = 0;
	int   in_idle_max   = 12;
	int   out_idle_max  = 12;
	bit   pressure_armed = 1'b0;

	// Bookkeeping
	int n_pushed     = 0;
	int n_in         = 0;
	int n_out        = 0;
	int n_writes     = 0;
	int fail_count   = 0;
	int stall_cycles = 0;

	vibration_rms_window_core #(
		.SAMPLE_WIDTH(SAMPLE_W)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.accel_x  (accel_x),
		.accel_y  (accel_y),
		.accel_z  (accel_z),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.rms_value(rms_value)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// floor square root, one result bit per pass from the top
	function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
		logic [31:0] r;
		logic [31:0] t;
		r = '0;
		for (int i = 31; i >= 0; i--) begin
			t = r | (32'd1 << i);
			if ({32'd0, t} * {32'd0, t} <= v)
				r = t;
		end
		return r;
	endfunction

	// two's complement magnitude; the most negative value needs the extra bit
	function automatic logic [SAMPLE_W:0] abs_field(input logic signed [SAMPLE_W-1:0] v);
		if (v[SAMPLE_W-1])
			return {(SAMPLE_W+1){1'b0}} - {v[SAMPLE_W-1], v};
		return {1'b0, v};
	endfunction

	// fold one sample into the window; closing the window predicts an RMS
	function automatic void accumulate_sample(input sample_t s);
		logic [SAMPLE_W:0]  ax, ay, az;
		logic [33:0]        sos;
		logic [31:0]        root;
		logic [15:0]        mag, diff;
		logic [31:0]        sq;
		logic [SUM_W:0]     wide_sum;
		logic [WIN_W:0]     win, taken;
		logic [SUM_W-1:0]   mean;
		ax = abs_field(s.x);
		ay = abs_field(s.y);
		az = abs_field(s.z);
		sos = ax * ax + ay * ay + az * az;
		root = floor_sqrt({30'd0, sos});
		mag = root[15:0];
		diff = (mag >= {1'b0, grav_cfg}) ? mag - {1'b0, grav_cfg} : {1'b0, grav_cfg} - mag;
		sq = diff * diff;
		wide_sum = {1'b0, acc_sum} + {9'd0, sq};
		acc_sum = wide_sum[SUM_W] ? SUM_MAX : wide_sum[SUM_W-1:0];
		// zero length counts as one
		win = (win_cfg == '0) ? 9'd1 : {1'b0, win_cfg};
		taken = {1'b0, acc_count} + 9'd1;
		if (taken < win) begin
			acc_count = taken[WIN_W-1:0];
		end else begin
			mean = acc_sum / taken;
			root = floor_sqrt({24'd0, mean});
			rms_expected.push_back((root > {16'd0, RMS_MAX}) ? RMS_MAX : root[15:0]);
			acc_sum = '0;
			acc_count = '0;
		end
	endfunction

	// ------------------------------------------------------------------------
	// Sample driver: presents queued samples on the falling edge
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		sample_t cur;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fire) begin
			if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap = in_gap - 1;
			end else if (sample_q.size() > 0) begin
				cur = sample_q.pop_front();
				accel_x <= cur.x;
				accel_y <= cur.y;
				accel_z <= cur.z;
				in_valid <= 1'b1;
				in_gap = $urandom_range(0, in_idle_max);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result receiver: ready drops for the drawn hold count
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (out_hold > 0) begin
			out_ready <= 1'b0;
			out_hold = out_hold - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: predicts on input transactions, checks output transactions
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		logic [RMS_W-1:0] want;
		bit               moved;
		if (arst_n) begin
			moved = 1'b0;
			in_fire <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				accumulate_sample('{x: accel_x, y: accel_y, z: accel_z});
				n_in++;
				moved = 1'b1;
			end
			if (out_valid && out_ready) begin
				moved = 1'b1;
				n_out++;
				if (rms_expected.size() == 0) begin
					if (fail_count < REPORT_LIMIT)
						$display("%0t: unexpected rms_value %0d", $realtime, rms_value);
					fail_count++;
				end else begin
					want = rms_expected.pop_front();
					if (rms_value !== want) begin
						if (fail_count < REPORT_LIMIT)
							$display("%0t: rms_value mismatch, expected %0d, got %0d",
								$realtime, want, rms_value);
						fail_count++;
					end
				end
				// long hold-off once, so the core backs up and stalls its input
				if (pressure_armed) begin
					out_hold = PRESSURE_CYCLES;
					pressure_armed = 1'b0;
				end else begin
					out_hold = $urandom_range(0, out_idle_max);
				end
			end
			// watchdog on cycles without any transaction
			if (moved)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", stall_cycles);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	task automatic push_sample(input int x, input int y, input int z);
		sample_q.push_back('{x: SAMPLE_W'(x), y: SAMPLE_W'(y), z: SAMPLE_W'(z)});
		n_pushed++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_WINDOW_LENGTH:  win_cfg = data[WIN_W-1:0];
			CFG_GRAVITY_OFFSET: grav_cfg = data[GRAV_W-1:0];
			default: ;
		endcase
		n_writes++;
	endtask

	// wait for all samples taken and all results back, then let the core settle
	task automatic wait_idle();
		do
			@(posedge clk);
		while (sample_q.size() != 0 || in_valid || rms_expected.size() != 0);
		repeat (IDLE_SETTLE) @(posedge clk);
	endtask

	function automatic int corner_value();
		case ($urandom_range(0, 4))
			0: return -32768;
			1: return 32767;
			2: return 0;
			3: return -1;
			default: return 1;
		endcase
	endfunction

	function automatic int noise(input int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// mix of resting sensor, shaking sensor, corners and raw noise
	task automatic push_random_sample();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			push_sample(noise(600), noise(600), 4096 + noise(1500));
		else if (pick < 6)
			push_sample(noise(12000), noise(12000), noise(12000));
		else if (pick < 7)
			push_sample(corner_value(), corner_value(), corner_value());
		else
			push_sample(int'($urandom), int'($urandom), int'($urandom));
	endtask

	task automatic random_setting();
		int unsigned      pick;
		logic [WIN_W-1:0]  w;
		logic [GRAV_W-1:0] g;
		pick = $urandom_range(0, 19);
		if (pick < 5)
			w = 8'd1;
		else if (pick < 15)
			w = WIN_W'($urandom_range(2, 8));
		else if (pick < 19)
			w = WIN_W'($urandom_range(9, 40));
		else
			w = '0;
		case ($urandom_range(0, 3))
			0: g = GRAVITY_OFFSET_RST;
			1: g = GRAV_W'($urandom);
			2: g = ($urandom_range(0, 1) == 0) ? '0 : '1;
			default: g = GRAV_W'(4096 + noise(800));
		endcase
		// upper bits of the window write carry junk that must be dropped
		write_reg(CFG_WINDOW_LENGTH, {7'($urandom), w});
		write_reg(CFG_GRAVITY_OFFSET, g);
		in_idle_max = ($urandom_range(0, 9) < 7) ? 12 : 0;
		out_idle_max = ($urandom_range(0, 9) < 7) ? 12 : 0;
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		int n_phase;
		bit pressure_done;
		pressure_done = 1'b0;
		out_hold = $urandom_range(0, 12);
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// reset values: window of 50, one g offset; leaves a partial window
		for (int i = 0; i < 60; i++)
			push_random_sample();
		wait_idle();

		// window of one (junk above bit 7), no offset; the partial window
		// left above closes on the first sample
		write_reg(CFG_WINDOW_LENGTH, 15'h7F01);
		write_reg(CFG_GRAVITY_OFFSET, 15'h0000);
		push_sample(0, 0, 0);
		push_sample(32767, 32767, 32767);
		push_sample(-32768, -32768, -32768);
		push_sample(-32768, 0, 0);
		push_sample(0, -32768, 0);
		push_sample(0, 0, -32768);
		push_sample(32767, -32768, 32767);
		push_sample(-1, -1, -1);
		push_sample(1, 0, 0);
		push_sample(0, 0, 4096);
		push_sample(2896, 2896, 0);
		push_sample(-4096, 0, 0);
		wait_idle();

		// zero window length acts as one; largest offset; spare indexes ignored
		write_reg(CFG_WINDOW_LENGTH, 15'h5500);
		write_reg(CFG_GRAVITY_OFFSET, 15'h7FFF);
		write_reg(CFG_SPARE_2, CFG_DATA_W'($urandom));
		write_reg(CFG_SPARE_3, '1);
		push_sample(0, 0, 0);
		push_sample(-32768, -32768, -32768);
		push_sample(0, 0, 4096);
		push_sample(32767, 0, 0);
		push_sample(-32768, 32767, -1);
		wait_idle();

		// window shortened below the samples already taken
		write_reg(CFG_WINDOW_LENGTH, 15'h000A);
		write_reg(CFG_GRAVITY_OFFSET, GRAVITY_OFFSET_RST);
		for (int i = 0; i < 7; i++)
			push_random_sample();
		wait_idle();
		write_reg(CFG_WINDOW_LENGTH, 15'h2A04);
		push_sample(-32768, 32767, 4096);
		wait_idle();

		// longest window
		write_reg(CFG_WINDOW_LENGTH, 15'h00FF);
		for (int i = 0; i < 300; i++)
			push_random_sample();
		wait_idle();

		// random phases, one of them under heavy back-pressure
		while (n_pushed < RANDOM_ITEMS) begin
			if (!pressure_done && n_pushed > 600) begin
				write_reg(CFG_WINDOW_LENGTH, 15'h0001);
				in_idle_max = 0;
				out_idle_max = 0;
				pressure_armed = 1'b1;
				pressure_done = 1'b1;
				n_phase = 60;
			end else begin
				random_setting();
				n_phase = $urandom_range(20, 60);
			end
			for (int i = 0; i < n_phase; i++)
				push_random_sample();
			wait_idle();
		end

		$display("Summary: %0d samples sent, %0d RMS results checked, %0d register writes",
			n_in, n_out, n_writes);
		$display("Windows of 0, 1, small, 255 and shortened mid-window; offsets 0 to max");
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("mismatches: %0d", fail_count);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
sv/vrw_pkg.sv
sv/vrw_isqrt.sv
sv/vrw_div.sv
sv/vibration_rms_window_core.sv
test/tb.sv
